// ===== rtl/lgps_pkg.sv =====
// ============================================================================
// Linear gradient pixel shader package
// Shared widths, register indexes, channel helpers and the structs passed
// between the configuration block and the two pipeline halves.
// ============================================================================
`default_nettype none

package lgps_pkg;

    localparam int COORD_W     = 12;
    localparam int SIZE_W      = 11;
    localparam int LIM_W       = COORD_W + 1;
    localparam int COLOR_W     = 16;
    localparam int POINT_W     = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int DELTA_W     = 13;
    localparam int OFS_W       = 14;
    localparam int PROJ_W      = 27;
    localparam int REL_W       = PROJ_W + 1;
    localparam int NUM_W       = 27;
    localparam int CH_W        = 6;
    localparam int R_W         = 5;
    localparam int G_W         = 6;
    localparam int B_W         = 5;
    localparam int QUO_W       = CH_W;
    localparam int PROD_W      = NUM_W + QUO_W;
    localparam int NUM_CH      = 3;
    localparam int ADDR_W      = 15;
    localparam int IN_TDATA_W  = 2 * COORD_W;
    localparam int OUT_TDATA_W = 32;

    localparam int FRONT_STAGES = 5;
    localparam int LERP_STAGES  = QUO_W + 2;

    localparam int FRAME_WIDTH_DEF  = 160;
    localparam int FRAME_HEIGHT_DEF = 128;

    localparam logic [CFG_IDX_W-1:0] REG_RECT_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_W      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_H      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRAD_START  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GRAD_END    = 3'd7;

    localparam int CH_B = 0;
    localparam int CH_G = 1;
    localparam int CH_R = 2;

    typedef struct packed {
        logic signed [COORD_W-1:0]  sx;
        logic signed [COORD_W-1:0]  sy;
        logic signed [DELTA_W-1:0]  dx;
        logic signed [DELTA_W-1:0]  dy;
        logic signed [PROJ_W-1:0]   minp;
        logic        [NUM_W-1:0]    den;
        logic [NUM_CH-1:0][CH_W-1:0] mag;
        logic [NUM_CH-1:0]          neg;
        logic        [COLOR_W-1:0]  start_color;
        logic        [COLOR_W-1:0]  end_color;
    } t_grad_cfg;

    typedef struct packed {
        logic [NUM_W-1:0]  num;
        logic [ADDR_W-1:0] addr;
        logic              we;
    } t_front_beat;

    function automatic logic [CH_W-1:0] color_chan(input logic [COLOR_W-1:0] c,
                                                   input int ch);
        logic [CH_W-1:0] v;
        if (ch == CH_R) begin
            v = CH_W'(c[COLOR_W-1 -: R_W]);
        end else if (ch == CH_G) begin
            v = c[B_W +: G_W];
        end else begin
            v = CH_W'(c[B_W-1:0]);
        end
        return v;
    endfunction

    function automatic logic [COLOR_W-1:0] pack_color(input logic [CH_W-1:0] r,
                                                      input logic [CH_W-1:0] g,
                                                      input logic [CH_W-1:0] b);
        return {r[R_W-1:0], g[G_W-1:0], b[B_W-1:0]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lgps_cfg.sv =====
// ============================================================================
// Gradient configuration registers
// Holds the written registers and derives, over four register stages, the
// gradient vector, the projection range of the rectangle corners and the
// per-channel color differences.
// ============================================================================
`default_nettype none

module lgps_cfg import lgps_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_index,
    input  wire logic [CFG_DATA_W-1:0] i_data,
    output t_grad_cfg                  o_cfg
);

    logic [COORD_W-1:0] r_rect_x;
    logic [COORD_W-1:0] r_rect_y;
    logic [SIZE_W-1:0]  r_rect_w;
    logic [SIZE_W-1:0]  r_rect_h;
    logic [COLOR_W-1:0] r_start_color;
    logic [COLOR_W-1:0] r_end_color;
    logic [POINT_W-1:0] r_grad_start;
    logic [POINT_W-1:0] r_grad_end;

    logic signed [COORD_W-1:0] n_sx, n_sy, r_sx, r_sy;
    logic signed [DELTA_W-1:0] n_dx, n_dy, r_dx, r_dy;
    logic signed [OFS_W-1:0]   n_ox0, n_ox1, n_oy0, n_oy1;
    logic signed [OFS_W-1:0]   r_ox0, r_ox1, r_oy0, r_oy1;
    logic [NUM_CH-1:0][CH_W-1:0] n_mag, r_mag;
    logic [NUM_CH-1:0]           n_neg, r_neg;
    logic signed [PROJ_W-1:0]  r_px0, r_px1, r_py0, r_py1;
    logic signed [PROJ_W-1:0]  n_minp, n_maxp, r_minp, r_maxp;
    logic [NUM_W-1:0]          r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_x      <= '0;
            r_rect_y      <= '0;
            r_rect_w      <= '0;
            r_rect_h      <= '0;
            r_start_color <= '0;
            r_end_color   <= '0;
            r_grad_start  <= '0;
            r_grad_end    <= '0;
        end else if (i_wr_en) begin
            unique case (i_index)
                REG_RECT_X:      r_rect_x      <= i_data[COORD_W-1:0];
                REG_RECT_Y:      r_rect_y      <= i_data[COORD_W-1:0];
                REG_RECT_W:      r_rect_w      <= i_data[SIZE_W-1:0];
                REG_RECT_H:      r_rect_h      <= i_data[SIZE_W-1:0];
                REG_START_COLOR: r_start_color <= i_data[COLOR_W-1:0];
                REG_END_COLOR:   r_end_color   <= i_data[COLOR_W-1:0];
                REG_GRAD_START:  r_grad_start  <= i_data[POINT_W-1:0];
                REG_GRAD_END:    r_grad_end    <= i_data[POINT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic signed [COORD_W-1:0] ex, ey, rx, ry;
        logic [CH_W-1:0] src, dst;
        logic [CH_W:0]   diff, neg_diff;
        n_sx  = $signed(r_grad_start[COORD_W-1:0]);
        n_sy  = $signed(r_grad_start[POINT_W-1:COORD_W]);
        ex    = $signed(r_grad_end[COORD_W-1:0]);
        ey    = $signed(r_grad_end[POINT_W-1:COORD_W]);
        rx    = $signed(r_rect_x);
        ry    = $signed(r_rect_y);
        n_dx  = DELTA_W'(ex) - DELTA_W'(n_sx);
        n_dy  = DELTA_W'(ey) - DELTA_W'(n_sy);
        n_ox0 = OFS_W'(rx) - OFS_W'(n_sx);
        n_oy0 = OFS_W'(ry) - OFS_W'(n_sy);
        n_ox1 = OFS_W'(rx) + OFS_W'($signed({1'b0, r_rect_w})) - OFS_W'(n_sx);
        n_oy1 = OFS_W'(ry) + OFS_W'($signed({1'b0, r_rect_h})) - OFS_W'(n_sy);
        for (int c = 0; c < NUM_CH; c++) begin
            src      = color_chan(r_start_color, c);
            dst      = color_chan(r_end_color, c);
            diff     = {1'b0, dst} - {1'b0, src};
            neg_diff = -diff;
            n_neg[c] = diff[CH_W];
            n_mag[c] = diff[CH_W] ? neg_diff[CH_W-1:0] : diff[CH_W-1:0];
        end
        n_minp = ((r_px0 < r_px1) ? r_px0 : r_px1) + ((r_py0 < r_py1) ? r_py0 : r_py1);
        n_maxp = ((r_px0 > r_px1) ? r_px0 : r_px1) + ((r_py0 > r_py1) ? r_py0 : r_py1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx   <= '0;
            r_sy   <= '0;
            r_dx   <= '0;
            r_dy   <= '0;
            r_ox0  <= '0;
            r_ox1  <= '0;
            r_oy0  <= '0;
            r_oy1  <= '0;
            r_mag  <= '0;
            r_neg  <= '0;
            r_px0  <= '0;
            r_px1  <= '0;
            r_py0  <= '0;
            r_py1  <= '0;
            r_minp <= '0;
            r_maxp <= '0;
            r_den  <= '0;
        end else begin
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_ox0  <= n_ox0;
            r_ox1  <= n_ox1;
            r_oy0  <= n_oy0;
            r_oy1  <= n_oy1;
            r_mag  <= n_mag;
            r_neg  <= n_neg;
            r_px0  <= PROJ_W'(r_ox0) * PROJ_W'(r_dx);
            r_px1  <= PROJ_W'(r_ox1) * PROJ_W'(r_dx);
            r_py0  <= PROJ_W'(r_oy0) * PROJ_W'(r_dy);
            r_py1  <= PROJ_W'(r_oy1) * PROJ_W'(r_dy);
            r_minp <= n_minp;
            r_maxp <= n_maxp;
            r_den  <= NUM_W'(r_maxp - r_minp);
        end
    end

    always_comb begin
        o_cfg.sx          = r_sx;
        o_cfg.sy          = r_sy;
        o_cfg.dx          = r_dx;
        o_cfg.dy          = r_dy;
        o_cfg.minp        = r_minp;
        o_cfg.den         = r_den;
        o_cfg.mag         = r_mag;
        o_cfg.neg         = r_neg;
        o_cfg.start_color = r_start_color;
        o_cfg.end_color   = r_end_color;
    end

endmodule

`default_nettype wire

// ===== rtl/lgps_front.sv =====
// ============================================================================
// Gradient projection pipeline
// Five stages: offset from the gradient start, projection products, their
// sum, offset from the corner minimum and clamping to the range. The frame
// address and write enable are formed alongside.
// ============================================================================
`default_nettype none

module lgps_front import lgps_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_grad_cfg                 i_cfg,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic signed [COORD_W-1:0] i_col,
    input  wire logic signed [COORD_W-1:0] i_row,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output t_front_beat                    o_beat
);

    localparam int LAST = FRONT_STAGES - 1;

    logic [FRONT_STAGES-1:0] r_v;
    logic [FRONT_STAGES-1:0] w_en;

    logic signed [OFS_W-1:0]  n_dcol, n_drow, r_a_dcol, r_a_drow;
    logic [SIZE_W-1:0]        r_a_col_u, r_a_row_u;
    logic                     n_we;
    logic signed [PROJ_W-1:0] r_b_pcol, r_b_prow, r_c_p;
    logic [ADDR_W-1:0]        n_addr;
    logic signed [REL_W-1:0]  r_d_rel;
    logic [NUM_W-1:0]         n_num, r_e_num;
    logic [FRONT_STAGES-1:0]  r_we;
    logic [FRONT_STAGES-1:1][ADDR_W-1:0] r_addr;

    always_comb begin
        w_en[LAST] = !r_v[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < FRONT_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        logic col_in, row_in;
        n_dcol = OFS_W'(i_col) - OFS_W'(i_cfg.sx);
        n_drow = OFS_W'(i_row) - OFS_W'(i_cfg.sy);
        col_in = !i_col[COORD_W-1] && (LIM_W'({1'b0, i_col}) < LIM_W'(FRAME_WIDTH));
        row_in = !i_row[COORD_W-1] && (LIM_W'({1'b0, i_row}) < LIM_W'(FRAME_HEIGHT));
        n_we   = col_in && row_in;
        n_addr = r_we[0] ? ADDR_W'(ADDR_W'(r_a_row_u) * ADDR_W'(FRAME_WIDTH)
                                   + ADDR_W'(r_a_col_u)) : '0;
        priority if (r_d_rel[REL_W-1]) begin
            n_num = '0;
        end else if (r_d_rel > $signed({1'b0, i_cfg.den})) begin
            n_num = i_cfg.den;
        end else begin
            n_num = r_d_rel[NUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a_dcol  <= n_dcol;
            r_a_drow  <= n_drow;
            r_a_col_u <= i_col[SIZE_W-1:0];
            r_a_row_u <= i_row[SIZE_W-1:0];
            r_we[0]   <= n_we;
        end
        if (w_en[1]) begin
            r_b_pcol  <= PROJ_W'(r_a_dcol) * PROJ_W'(i_cfg.dx);
            r_b_prow  <= PROJ_W'(r_a_drow) * PROJ_W'(i_cfg.dy);
            r_addr[1] <= n_addr;
        end
        if (w_en[2]) begin
            r_c_p <= r_b_pcol + r_b_prow;
        end
        if (w_en[3]) begin
            r_d_rel <= REL_W'(r_c_p) - REL_W'(i_cfg.minp);
        end
        if (w_en[4]) begin
            r_e_num <= n_num;
        end
        for (int k = 1; k < FRONT_STAGES; k++) begin
            if (w_en[k]) begin
                r_we[k] <= r_we[k-1];
            end
        end
        for (int k = 2; k < FRONT_STAGES; k++) begin
            if (w_en[k]) begin
                r_addr[k] <= r_addr[k-1];
            end
        end
    end

    assign o_ready     = w_en[0];
    assign o_valid     = r_v[LAST];
    assign o_beat.num  = r_e_num;
    assign o_beat.addr = r_addr[LAST];
    assign o_beat.we   = r_we[LAST];

endmodule

`default_nettype wire

// ===== rtl/lgps_lerp.sv =====
// ============================================================================
// Color interpolation pipeline
// Scales each channel difference by the clamped position, divides by the
// range in a pipelined restoring divider of one quotient bit per stage and
// adds the signed step to the start color (end color for a zero range).
// ============================================================================
`default_nettype none

module lgps_lerp import lgps_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_grad_cfg    i_cfg,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire t_front_beat  i_beat,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [COLOR_W-1:0] o_color,
    output logic [ADDR_W-1:0] o_addr,
    output logic              o_we
);

    localparam int LAST = LERP_STAGES - 1;

    logic [LERP_STAGES-1:0] r_v;
    logic [LERP_STAGES-1:0] w_en;

    logic [QUO_W-1:0][NUM_CH-1:0][PROD_W-1:0] n_rem, r_rem;
    logic [QUO_W-1:0][NUM_CH-1:0][QUO_W-1:0]  n_q, r_q;
    logic [NUM_CH-1:0][PROD_W-1:0]            n_prod;
    logic [COLOR_W-1:0]                       n_color, r_color;
    logic [LERP_STAGES-1:0][ADDR_W-1:0]       r_addr;
    logic [LERP_STAGES-1:0]                   r_we;

    always_comb begin
        w_en[LAST] = !r_v[LAST] || i_ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < LERP_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_comb begin
        logic [PROD_W-1:0] dsh;
        logic [QUO_W-1:0]  q_in;
        logic              ge;
        for (int c = 0; c < NUM_CH; c++) begin
            n_prod[c] = PROD_W'(i_cfg.mag[c]) * PROD_W'(i_beat.num);
        end
        for (int j = 0; j < QUO_W; j++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                dsh = PROD_W'(i_cfg.den) << (QUO_W - 1 - j);
                if (j == 0) begin
                    q_in = '0;
                end else begin
                    q_in = r_q[j-1][c];
                end
                ge                     = r_rem[j][c] >= dsh;
                n_rem[j][c]            = ge ? (r_rem[j][c] - dsh) : r_rem[j][c];
                n_q[j][c]              = q_in;
                n_q[j][c][QUO_W-1-j]   = ge;
            end
        end
    end

    always_comb begin
        logic [NUM_CH-1:0][CH_W-1:0] ch;
        logic [CH_W-1:0] src;
        for (int c = 0; c < NUM_CH; c++) begin
            src   = color_chan(i_cfg.start_color, c);
            ch[c] = i_cfg.neg[c] ? (src - r_q[QUO_W-1][c]) : (src + r_q[QUO_W-1][c]);
        end
        if (i_cfg.den == '0) begin
            n_color = i_cfg.end_color;
        end else begin
            n_color = pack_color(ch[CH_R], ch[CH_G], ch[CH_B]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_rem[0]  <= n_prod;
            r_addr[0] <= i_beat.addr;
            r_we[0]   <= i_beat.we;
        end
        for (int j = 0; j < QUO_W; j++) begin
            if (w_en[j+1]) begin
                r_q[j] <= n_q[j];
                if (j < QUO_W - 1) begin
                    r_rem[j+1] <= n_rem[j];
                end
            end
        end
        if (w_en[LAST]) begin
            r_color <= n_color;
        end
        for (int k = 1; k < LERP_STAGES; k++) begin
            if (w_en[k]) begin
                r_addr[k] <= r_addr[k-1];
                r_we[k]   <= r_we[k-1];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[LAST];
    assign o_color = r_color;
    assign o_addr  = r_addr[LAST];
    assign o_we    = r_we[LAST];

endmodule

`default_nettype wire

// ===== rtl/linear_gradient_pixel_shader.sv =====
// ============================================================================
// Linear gradient pixel shader
// Shades one pixel coordinate per beat with an RGB565 linear gradient and
// returns its frame address and an in-frame write enable.
// ============================================================================
// The shader takes one pixel beat per clock cycle while not stalled. Five
// stages project the pixel onto the gradient and clamp it to the rectangle's
// range, one stage scales the channel differences, six stages run the
// restoring divider one quotient bit at a time, and one output register
// holds the result. Stalls on the output side fill empty stages first, so
// the input stays ready until all 13 stages hold a beat. Derived
// configuration is registered after a register write; write registers only
// while no beat is in flight.
`default_nettype none

module linear_gradient_pixel_shader import lgps_pkg::*; #(
    parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0: pixel_col[11:0], pixel_row[23:12].
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // Fields from bit 0: shaded_color[15:0], frame_address[30:16], zero pad.
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // Fields from bit 0: write_enable[0].
    output logic                        m_axis_tuser
);

    t_grad_cfg          w_cfg;
    t_front_beat        w_beat;
    logic               w_beat_valid;
    logic               w_beat_ready;
    logic [COLOR_W-1:0] w_color;
    logic [ADDR_W-1:0]  w_addr;
    logic               w_we;

    lgps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    lgps_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_col   ($signed(s_axis_tdata[COORD_W-1:0])),
        .i_row   ($signed(s_axis_tdata[IN_TDATA_W-1:COORD_W])),
        .o_valid (w_beat_valid),
        .i_ready (w_beat_ready),
        .o_beat  (w_beat)
    );

    lgps_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_beat_valid),
        .o_ready (w_beat_ready),
        .i_beat  (w_beat),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_color (w_color),
        .o_addr  (w_addr),
        .o_we    (w_we)
    );

    assign m_axis_tdata = OUT_TDATA_W'({w_addr, w_color});
    assign m_axis_tuser = w_we;

    a_addr_zero_off_frame: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[COLOR_W +: ADDR_W] == '0)
    ) else $error("frame address not zero for a pixel outside the frame");

    a_ready_only_blocked_by_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready)
    ) else $error("input stalled while the output side is not stalled");

    a_pad_bit_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1] == 1'b0)
    ) else $error("output pad bit set");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ============================================================================
// Linear gradient pixel shader testbench
// Streams pixel coordinates into the shader under a series of rectangle,
// color and gradient settings, predicts each RGB565 color, frame address
// and write enable with exact integer arithmetic, and checks every output
// beat in order while both stream sides idle in random bursts in some phases.
// ============================================================================
module tb import lgps_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [ADDR_W-1:0]  addr;
        logic               we;
    } t_shade;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    logic [CFG_DATA_W-1:0]  cfg_reg [8];
    logic [IN_TDATA_W-1:0]  pixel_q [$];
    t_shade                 pending_shades [$];
    t_shade                 head_shade;
    bit                     idling = 1'b0;
    bit                     src_take;
    int unsigned            src_gap = 0;
    int unsigned            sink_gap = 0;
    int                     sent_beats = 0;
    int                     checked_beats = 0;
    int                     errors = 0;
    int                     setups = 0;

    linear_gradient_pixel_shader uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint mix_channel(input longint s, input longint e,
                                           input longint num, input longint den);
        if (den == 0) begin
            return e;
        end
        return s + ((e - s) * num) / den;
    endfunction

    function automatic t_shade shade_pixel(input logic [IN_TDATA_W-1:0] beat);
        longint col, row, sx, sy, dx, dy, rx, ry, w, h, cx, cy, cp;
        longint lo, hi, num, den, r, g, b;
        logic [COLOR_W-1:0] sc, ec;
        t_shade res;
        col = longint'($signed(beat[COORD_W-1:0]));
        row = longint'($signed(beat[2*COORD_W-1:COORD_W]));
        sx = longint'($signed(cfg_reg[REG_GRAD_START][11:0]));
        sy = longint'($signed(cfg_reg[REG_GRAD_START][23:12]));
        dx = longint'($signed(cfg_reg[REG_GRAD_END][11:0])) - sx;
        dy = longint'($signed(cfg_reg[REG_GRAD_END][23:12])) - sy;
        rx = longint'($signed(cfg_reg[REG_RECT_X][11:0]));
        ry = longint'($signed(cfg_reg[REG_RECT_Y][11:0]));
        w = longint'(cfg_reg[REG_RECT_W][10:0]);
        h = longint'(cfg_reg[REG_RECT_H][10:0]);
        lo = 0;
        hi = 0;
        for (int i = 0; i < 4; i++) begin
            cx = rx + ((i & 1) ? w : 0);
            cy = ry + ((i & 2) ? h : 0);
            cp = (cx - sx) * dx + (cy - sy) * dy;
            if (i == 0 || cp < lo) lo = cp;
            if (i == 0 || cp > hi) hi = cp;
        end
        den = hi - lo;
        num = (col - sx) * dx + (row - sy) * dy - lo;
        if (num < 0) num = 0;
        if (num > den) num = den;
        sc = cfg_reg[REG_START_COLOR][15:0];
        ec = cfg_reg[REG_END_COLOR][15:0];
        r = mix_channel(longint'(sc[15:11]), longint'(ec[15:11]), num, den);
        g = mix_channel(longint'(sc[10:5]), longint'(ec[10:5]), num, den);
        b = mix_channel(longint'(sc[4:0]), longint'(ec[4:0]), num, den);
        res.color = {r[4:0], g[5:0], b[4:0]};
        res.we = (col >= 0 && col < FRAME_WIDTH_DEF && row >= 0 && row < FRAME_HEIGHT_DEF);
        res.addr = res.we ? ADDR_W'(row * FRAME_WIDTH_DEF + col) : '0;
        return res;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pt(input int x, input int y);
        return {12'(y), 12'(x)};
    endfunction

    task automatic report_mismatch(input string field, input longint got,
                                   input longint want);
        errors++;
        if (errors <= 100) begin
            $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                     checked_beats, field, got, want);
        end
    endtask

    // Pixel source.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            src_take = !s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                pending_shades.push_back(shade_pixel(s_axis_tdata));
                sent_beats++;
                src_take = 1'b1;
            end
            if (src_take) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    s_axis_tdata <= pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (idling && $urandom_range(0, 11) == 0) begin
                        src_gap <= $urandom_range(1, 15);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result sink backpressure.
    always @(posedge i_clk) begin
        if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n;
            if (idling && $urandom_range(0, 9) == 0) begin
                sink_gap <= $urandom_range(1, 15);
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_shades.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata, 0);
            end else begin
                head_shade = pending_shades.pop_front();
                if (m_axis_tdata[15:0] != head_shade.color)
                    report_mismatch("shaded_color", m_axis_tdata[15:0], head_shade.color);
                if (m_axis_tdata[30:16] != head_shade.addr)
                    report_mismatch("frame_address", m_axis_tdata[30:16], head_shade.addr);
                if (m_axis_tuser != head_shade.we)
                    report_mismatch("write_enable", m_axis_tuser, head_shade.we);
            end
            checked_beats++;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        cfg_reg[idx] = val;
    endtask

    task automatic apply_setup(input int rx, input int ry, input int w, input int h,
                               input logic [15:0] sc, input logic [15:0] ec,
                               input logic [23:0] gs, input logic [23:0] ge);
        write_reg(REG_RECT_X, 24'(12'(rx)));
        write_reg(REG_RECT_Y, 24'(12'(ry)));
        write_reg(REG_RECT_W, 24'(11'(w)));
        write_reg(REG_RECT_H, 24'(11'(h)));
        write_reg(REG_START_COLOR, 24'(sc));
        write_reg(REG_END_COLOR, 24'(ec));
        write_reg(REG_GRAD_START, gs);
        write_reg(REG_GRAD_END, ge);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        repeat (8) @(posedge i_clk);
        setups++;
    endtask

    task automatic drain;
        @(negedge i_clk);
        while (pixel_q.size() > 0 || s_axis_tvalid || pending_shades.size() > 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic int pick_coord();
        case ($urandom_range(0, 7))
            0: return -2048;
            1: return 2047;
            2: return 0;
            3, 4: return int'($urandom_range(0, 200)) - 20;
            default: return $signed(12'($urandom));
        endcase
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 2047;
            2, 3, 4: return $urandom_range(0, 200);
            default: return $urandom_range(0, 2047);
        endcase
    endfunction

    initial begin
        int n, rx, ry, w, h;
        logic [23:0] gs;
        for (int i = 0; i < 8; i++) cfg_reg[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // Registers still at their reset values: zero range, black.
        pixel_q.push_back(pt(0, 0));
        pixel_q.push_back(pt(159, 127));
        drain();

        // Equal gradient points give a zero range.
        apply_setup(0, 0, 159, 127, 16'hF81F, 16'h07E0, pt(20, 30), pt(20, 30));
        pixel_q.push_back(pt(10, 10));
        pixel_q.push_back(pt(-2048, -2048));
        drain();

        // Horizontal gradient over the frame, frame edges, clamping outside.
        apply_setup(0, 0, 159, 127, 16'hF800, 16'h001F, pt(0, 0), pt(159, 0));
        pixel_q.push_back(pt(0, 0));
        pixel_q.push_back(pt(80, 64));
        pixel_q.push_back(pt(159, 127));
        pixel_q.push_back(pt(160, 127));
        pixel_q.push_back(pt(159, 128));
        pixel_q.push_back(pt(-1, 0));
        pixel_q.push_back(pt(0, -1));
        pixel_q.push_back(pt(2047, 2047));
        pixel_q.push_back(pt(-2048, 2047));
        pixel_q.push_back(pt(2047, -2048));
        pixel_q.push_back(pt(37, 100));
        drain();

        // Extreme corner and gradient values.
        apply_setup(-2048, -2048, 2047, 2047, 16'hFFFF, 16'h0000,
                    pt(-2048, -2048), pt(2047, 2047));
        pixel_q.push_back(pt(-2048, -2048));
        pixel_q.push_back(pt(2047, 2047));
        pixel_q.push_back(pt(0, 0));
        pixel_q.push_back(pt(-1, -1));
        drain();

        apply_setup(2047, 2047, 2047, 2047, 16'h0000, 16'hFFFF,
                    pt(-2048, -2048), pt(2047, 2047));
        pixel_q.push_back(pt(2047, 2047));
        pixel_q.push_back(pt(-2048, -2048));
        pixel_q.push_back(pt(100, 50));
        drain();

        // Degenerate rectangle with a real gradient direction.
        apply_setup(50, 60, 0, 0, 16'h1234, 16'hABCD, pt(0, 0), pt(10, -7));
        pixel_q.push_back(pt(50, 60));
        pixel_q.push_back(pt(0, 0));
        pixel_q.push_back(pt(159, 0));
        drain();

        for (int ph = 0; ph < 20; ph++) begin
            idling = (ph != 19) && ($urandom_range(0, 3) != 0);
            rx = pick_coord();
            ry = pick_coord();
            w = pick_size();
            h = pick_size();
            gs = pt(pick_coord(), pick_coord());
            apply_setup(rx, ry, w, h, 16'($urandom), 16'($urandom), gs,
                        ($urandom_range(0, 7) == 0) ? gs : pt(pick_coord(), pick_coord()));
            n = $urandom_range(50, 100);
            repeat (n) begin
                case ($urandom_range(0, 7))
                    0, 1, 2, 3, 4:
                        pixel_q.push_back(pt(int'($urandom_range(0, 179)) - 10,
                                             int'($urandom_range(0, 147)) - 10));
                    5, 6:
                        pixel_q.push_back(pt(rx + int'($urandom_range(0, w)),
                                             ry + int'($urandom_range(0, h))));
                    default:
                        pixel_q.push_back(24'($urandom));
                endcase
            end
            drain();
        end

        $display("Shaded %0d pixel beats under %0d register setups, %0d results checked.",
                 sent_beats, setups + 1, checked_beats);
        $display("Covered zero ranges, clamping, frame edges and extreme coordinates.");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
